// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int unsigned FW = 32;
	localparam int unsigned DW = 64;
	localparam int unsigned KW = 7;
	localparam int unsigned CW = 6;

	localparam logic [2:0] ACT_MAKE = 3'd0;
	localparam logic [2:0] ACT_ADD  = 3'd1;
	localparam logic [2:0] ACT_SUB  = 3'd2;
	localparam logic [2:0] ACT_MUL  = 3'd3;
	localparam logic [2:0] ACT_DIV  = 3'd4;
	localparam logic [2:0] ACT_CMP  = 3'd5;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_ZDEN = 2'd1;
	localparam logic [1:0] ERR_DIV0 = 2'd2;
	localparam logic [1:0] ERR_OVF  = 2'd3;

	typedef struct packed {
		logic start;
		logic done;
	} unit_hs_t;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction arithmetic with gcd reduction.
//
// Raise start with action and both fractions; the transaction is taken at a
// clock edge where start is high and busy is low. busy then stays high until
// the result is issued. The result fields are valid for the single cycle in
// which done is high; the receiver cannot stall, so it must capture them then.
// Each fraction is reduced in turn by one binary gcd unit and one shared
// restoring divider, which gives two quotients per reduction. make performs
// one reduction; add, subtract, multiply and divide perform three plus a
// product phase; compare performs two plus the product phase. A zero right
// denominator ends after the first reduction, and divide by a zero right
// fraction ends after the second. With a valid action, a zero left
// denominator ends the transaction at load with ERR_ZDEN; an unused action
// also ends there, with error code ERR_OK. busy drops in the cycle done is
// shown, so the next transaction may start then.
// Reset clears the sequencer, busy and done; no transaction is in flight.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int unsigned WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [31:0] lhs_num,
	input  logic signed [31:0] lhs_den,
	input  logic signed [31:0] rhs_num,
	input  logic signed [31:0] rhs_den,
	output logic               done,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic [1:0]         error_code,
	output logic               is_less,
	output logic               is_equal
);

	localparam logic [rau_pkg::DW-1:0] LIM =
		(rau_pkg::DW'(1) << (WORD_BITS - 1)) - rau_pkg::DW'(1);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_LOAD  = 11'b00000000010,
		S_GCD0  = 11'b00000000100,
		S_GCD1  = 11'b00000001000,
		S_DIVN0 = 11'b00000010000,
		S_DIVN1 = 11'b00000100000,
		S_DIVD0 = 11'b00001000000,
		S_DIVD1 = 11'b00010000000,
		S_NEXT  = 11'b00100000000,
		S_MUL   = 11'b01000000000,
		S_COMB  = 11'b10000000000
	} state_t;

	typedef enum logic [2:0] {
		PH_L   = 3'b001,
		PH_R   = 3'b010,
		PH_RES = 3'b100
	} phase_t;

	state_t                 state_q;
	phase_t                 phase_q;
	logic [2:0]             act_q;
	logic [31:0]            ln_q, ld_q, rn_q, rd_q;
	logic                   red_neg_q;
	logic [rau_pkg::DW-1:0] red_mag_q, red_den_q, qn_q, g_q;
	logic                   l_neg_q, r_neg_q;
	logic [31:0]            l_mag_q, l_den_q, r_mag_q, r_den_q;
	logic [rau_pkg::DW-1:0] p_q [3];
	logic [1:0]             mul_idx_q;
	logic                   done_q, less_q, eq_q;
	logic [31:0]            num_q;
	logic [30:0]            den_q;
	logic [1:0]             err_q;

	rau_pkg::unit_hs_t      gcd_hs, div_hs;
	logic [rau_pkg::DW-1:0] gcd_g, div_quot, div_dividend;

	logic                   ln_neg, ld_neg, rn_neg, rd_neg;
	logic [31:0]            ln_mag, ld_mag, rn_mag, rd_mag;
	logic [31:0]            mx, my;
	logic                   s1, s2, ss;
	logic [rau_pkg::DW-1:0] sm;
	logic                   ovf;

	assign gcd_hs.start = (state_q == S_GCD0);
	assign div_hs.start = (state_q == S_DIVN0) || (state_q == S_DIVD0);
	assign div_dividend = (state_q == S_DIVN0) ? red_mag_q : red_den_q;

	rau_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_hs.start),
		.a      (red_mag_q),
		.b      (red_den_q),
		.done   (gcd_hs.done),
		.g      (gcd_g)
	);

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_hs.start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.done     (div_hs.done),
		.quotient (div_quot)
	);

	always_comb begin
		ln_neg = ln_q[31];
		ld_neg = ld_q[31];
		rn_neg = rn_q[31];
		rd_neg = rd_q[31];
		ln_mag = ln_neg ? (~ln_q + 32'd1) : ln_q;
		ld_mag = ld_neg ? (~ld_q + 32'd1) : ld_q;
		rn_mag = rn_neg ? (~rn_q + 32'd1) : rn_q;
		rd_mag = rd_neg ? (~rd_q + 32'd1) : rd_q;

		case (mul_idx_q)
			2'd0: begin
				mx = l_mag_q;
				my = (act_q == rau_pkg::ACT_MUL) ? r_mag_q : r_den_q;
			end
			2'd1: begin
				mx = l_den_q;
				my = r_mag_q;
			end
			default: begin
				mx = l_den_q;
				my = (act_q == rau_pkg::ACT_DIV) ? r_mag_q : r_den_q;
			end
		endcase

		s1 = l_neg_q;
		s2 = (act_q == rau_pkg::ACT_ADD) ? r_neg_q : !r_neg_q;
		if (s1 == s2) begin
			ss = s1;
			sm = p_q[0] + p_q[1];
		end else if (p_q[0] >= p_q[1]) begin
			ss = s1;
			sm = p_q[0] - p_q[1];
		end else begin
			ss = s2;
			sm = p_q[1] - p_q[0];
		end
		if (sm == '0) begin
			ss = 1'b0;
		end

		ovf = (red_mag_q > LIM) || (red_den_q > LIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_L;
			mul_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (act_q > rau_pkg::ACT_CMP || ld_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						phase_q <= PH_L;
						state_q <= S_GCD0;
					end
				end
				S_GCD0:  state_q <= S_GCD1;
				S_GCD1: begin
					if (gcd_hs.done) begin
						state_q <= S_DIVN0;
					end
				end
				S_DIVN0: state_q <= S_DIVN1;
				S_DIVN1: begin
					if (div_hs.done) begin
						state_q <= S_DIVD0;
					end
				end
				S_DIVD0: state_q <= S_DIVD1;
				S_DIVD1: begin
					if (div_hs.done) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					case (phase_q)
						PH_L: begin
							if (act_q == rau_pkg::ACT_MAKE || rd_q == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								phase_q <= PH_R;
								state_q <= S_GCD0;
							end
						end
						PH_R: begin
							if (act_q == rau_pkg::ACT_DIV && red_mag_q == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								mul_idx_q <= '0;
								state_q   <= S_MUL;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MUL: begin
					mul_idx_q <= mul_idx_q + 2'd1;
					if (mul_idx_q == 2'd2) begin
						state_q <= S_COMB;
					end
				end
				S_COMB: begin
					if (act_q == rau_pkg::ACT_CMP) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						phase_q <= PH_RES;
						state_q <= S_GCD0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					act_q <= action;
					ln_q  <= lhs_num;
					ld_q  <= lhs_den;
					rn_q  <= rhs_num;
					rd_q  <= rhs_den;
				end
			end
			S_LOAD: begin
				num_q     <= '0;
				den_q     <= '0;
				less_q    <= 1'b0;
				eq_q      <= 1'b0;
				err_q     <= (act_q > rau_pkg::ACT_CMP) ? rau_pkg::ERR_OK : rau_pkg::ERR_ZDEN;
				red_neg_q <= ln_neg != ld_neg;
				red_mag_q <= rau_pkg::DW'(ln_mag);
				red_den_q <= rau_pkg::DW'(ld_mag);
			end
			S_GCD1: begin
				if (gcd_hs.done) begin
					g_q <= gcd_g;
				end
			end
			S_DIVN1: begin
				if (div_hs.done) begin
					qn_q <= div_quot;
				end
			end
			S_DIVD1: begin
				if (div_hs.done) begin
					red_mag_q <= qn_q;
					red_den_q <= div_quot;
					red_neg_q <= red_neg_q && (qn_q != '0);
				end
			end
			S_NEXT: begin
				case (phase_q)
					PH_L: begin
						l_neg_q <= red_neg_q;
						l_mag_q <= red_mag_q[31:0];
						l_den_q <= red_den_q[31:0];
						if (act_q == rau_pkg::ACT_MAKE) begin
							err_q <= ovf ? rau_pkg::ERR_OVF : rau_pkg::ERR_OK;
							num_q <= ovf ? '0 :
								(red_neg_q ? (~red_mag_q[31:0] + 32'd1) : red_mag_q[31:0]);
							den_q <= ovf ? '0 : red_den_q[30:0];
						end else if (rd_q == '0) begin
							err_q <= rau_pkg::ERR_ZDEN;
						end else begin
							red_neg_q <= rn_neg != rd_neg;
							red_mag_q <= rau_pkg::DW'(rn_mag);
							red_den_q <= rau_pkg::DW'(rd_mag);
						end
					end
					PH_R: begin
						r_neg_q <= red_neg_q;
						r_mag_q <= red_mag_q[31:0];
						r_den_q <= red_den_q[31:0];
						err_q   <= rau_pkg::ERR_DIV0;
					end
					default: begin
						err_q <= ovf ? rau_pkg::ERR_OVF : rau_pkg::ERR_OK;
						num_q <= ovf ? '0 :
							(red_neg_q ? (~red_mag_q[31:0] + 32'd1) : red_mag_q[31:0]);
						den_q <= ovf ? '0 : red_den_q[30:0];
					end
				endcase
			end
			S_MUL: begin
				p_q[mul_idx_q] <= rau_pkg::DW'(mx) * rau_pkg::DW'(my);
			end
			S_COMB: begin
				if (act_q == rau_pkg::ACT_CMP) begin
					err_q  <= rau_pkg::ERR_OK;
					less_q <= ss;
					eq_q   <= (l_neg_q == r_neg_q) && (l_mag_q == r_mag_q) &&
						(l_den_q == r_den_q);
				end else if (act_q == rau_pkg::ACT_ADD || act_q == rau_pkg::ACT_SUB) begin
					red_neg_q <= ss;
					red_mag_q <= sm;
					red_den_q <= p_q[2];
				end else begin
					red_neg_q <= l_neg_q != r_neg_q;
					red_mag_q <= p_q[0];
					red_den_q <= p_q[2];
				end
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign res_num    = num_q;
	assign res_den    = den_q;
	assign error_code = err_q;
	assign is_less    = less_q;
	assign is_equal   = eq_q;

endmodule

// ===== rtl/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd over 64-bit operands, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module rau_gcd (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rau_pkg::DW-1:0]    a,
	input  logic [rau_pkg::DW-1:0]    b,
	output logic                      done,
	output logic [rau_pkg::DW-1:0]    g
);

	logic                   busy_q;
	logic                   done_q;
	logic [rau_pkg::DW-1:0] a_q;
	logic [rau_pkg::DW-1:0] b_q;
	logic [rau_pkg::DW-1:0] g_q;
	logic [rau_pkg::KW-1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (a_q == '0 || b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			if (a_q == '0) begin
				g_q <= b_q << k_q;
			end else if (b_q == '0) begin
				g_q <= a_q << k_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + rau_pkg::KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

// ===== rtl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, 64-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rau_pkg::DW-1:0]    dividend,
	input  logic [rau_pkg::DW-1:0]    divisor,
	output logic                      done,
	output logic [rau_pkg::DW-1:0]    quotient
);

	logic                   busy_q;
	logic                   done_q;
	logic [rau_pkg::CW-1:0] cnt_q;
	logic [rau_pkg::DW-1:0] rem_q;
	logic [rau_pkg::DW-1:0] q_q;
	logic [rau_pkg::DW-1:0] d_q;
	logic [rau_pkg::DW:0]   trial;
	logic [rau_pkg::DW:0]   diff;
	logic                   qbit;

	always_comb begin
		trial = {rem_q, q_q[rau_pkg::DW-1]};
		diff  = trial - {1'b0, d_q};
		qbit  = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + rau_pkg::CW'(1);
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[rau_pkg::DW-1:0] : trial[rau_pkg::DW-1:0];
			q_q   <= {q_q[rau_pkg::DW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

// ===== rtl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] res_num,
	input logic [30:0] res_den,
	input logic [1:0]  error_code,
	input logic        is_less,
	input logic        is_equal
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted but busy not raised");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error_code != rau_pkg::ERR_OK) |-> (res_num == '0 && res_den == '0 &&
			!is_less && !is_equal))
		else $error("error result carries nonzero fields");

	a_less_eq: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_less && is_equal))
		else $error("compare reports both less and equal");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.res_num    (res_num),
	.res_den    (res_den),
	.error_code (error_code),
	.is_less    (is_less),
	.is_equal   (is_equal)
);
